### sv/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the digit-to-ASCII map for the unsigned to
// ASCII decimal/hex converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FIELD_W         = 64;
    localparam int MAX_DIGITS      = 20;
    localparam int DIG_W           = MAX_DIGITS * 4;
    localparam int CNT_W           = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] MODE_DEC    = 2'd0;
    localparam logic [1:0] MODE_HEX_LO = 2'd1;
    localparam logic [1:0] MODE_HEX_UP = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FIELD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
    } out_item_t;

    // classified command held in the queue
    typedef struct packed {
        logic               hex;
        logic               upper;
        logic [FIELD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_SKIP,
        B_EMIT
    } back_state_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] nib, input logic upper);
        logic [6:0] c;
        if (nib < 4'd10)
        begin
            c = 7'h30 + {3'b000, nib};
        end
        else if (upper)
        begin
            c = 7'h37 + {3'b000, nib};
        end
        else
        begin
            c = 7'h57 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

### sv/unsigned_to_ascii_dec_hex_top.sv
// A number passes the input hold register and the two-entry queue before the
// converter takes it; decimal then runs the serial shift-add-3 converter over
// every bit of the value, hex skips it. Leading zeros are then dropped one per
// cycle and digits emitted one per cycle while the output does not stall. The
// converter takes the next number from the queue only after emitting the last
// digit of the previous one; the input register and queue hold later numbers.
// Reset clears the queue, the converter state and both valid flags.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_dec_hex_top
// Unsigned binary to ASCII decimal / hex digits, most significant first.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_dec_hex_top #(
    parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u2a_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output u2a_pkg::out_item_t out_data
);
    import u2a_pkg::*;

    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;

    u2a_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    u2a_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    u2a_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### sv/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Input stage: takes one item, decodes the mode, masks the value and hands
// the command to the queue.
// ----------------------------------------------------------------------------
module u2a_front #(
    parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u2a_pkg::in_item_t  in_data,
    input  logic               q_full,
    output u2a_pkg::q_push_t   q_push
);
    import u2a_pkg::*;

    localparam logic [FIELD_W-1:0] VALUE_MASK = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_WIDTH);

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_cmd_reg, hold_cmd_next;
    cmd_t dec_cmd;
    logic accept;
    logic push;

    always_comb
    begin
        dec_cmd.value = in_data.value & VALUE_MASK;
        unique case (in_data.mode)
            MODE_HEX_LO:
            begin
                dec_cmd.hex   = 1'b1;
                dec_cmd.upper = 1'b0;
            end
            MODE_HEX_UP:
            begin
                dec_cmd.hex   = 1'b1;
                dec_cmd.upper = 1'b1;
            end
            default:
            begin
                // decimal, and the unused code treated as decimal
                dec_cmd.hex   = 1'b0;
                dec_cmd.upper = 1'b0;
            end
        endcase
    end

    assign push     = hold_valid_reg && !q_full;
    assign in_stall = hold_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = dec_cmd;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

    assign q_push.push = push;
    assign q_push.cmd  = hold_cmd_reg;

endmodule

### sv/u2a_fifo.sv
// ----------------------------------------------------------------------------
// u2a_fifo
// Two-entry command queue between the input stage and the converter.
// ----------------------------------------------------------------------------
module u2a_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  u2a_pkg::q_push_t q_push,
    output logic             q_full,
    output u2a_pkg::q_head_t q_head,
    input  logic             q_pop
);
    import u2a_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_full       = (count_reg == 2'd2);
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.cmd   = mem[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

### sv/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Converter: serial shift-add-3 binary to BCD for decimal, direct nibbles for
// hex, then drops leading zeros and emits one ASCII digit per transfer.
// ----------------------------------------------------------------------------
module u2a_back #(
    parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  u2a_pkg::q_head_t   q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output u2a_pkg::out_item_t out_data
);
    import u2a_pkg::*;

    localparam int BIT_W = $clog2(VALUE_WIDTH);

    back_state_t            state_reg, state_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BIT_W-1:0]       bitcnt_reg, bitcnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   upper_reg, upper_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;
    logic [DIG_W-1:0]       corr;
    logic [3:0]             top_nib;
    logic                   slot_free;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            corr[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ? dig_reg[i*4 +: 4] + 4'd3
                                                          : dig_reg[i*4 +: 4];
        end
    end

    assign top_nib   = dig_reg[DIG_W-1 -: 4];
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        bin_next       = bin_reg;
        bitcnt_next    = bitcnt_reg;
        cnt_next       = cnt_reg;
        upper_next     = upper_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop       = 1'b1;
                    upper_next  = q_head.cmd.upper;
                    cnt_next    = CNT_W'(MAX_DIGITS);
                    bitcnt_next = '0;
                    bin_next    = q_head.cmd.value[VALUE_WIDTH-1:0];
                    if (q_head.cmd.hex)
                    begin
                        dig_next   = DIG_W'(q_head.cmd.value[VALUE_WIDTH-1:0]);
                        state_next = B_SKIP;
                    end
                    else
                    begin
                        dig_next   = '0;
                        state_next = B_CONV;
                    end
                end
            end
            B_CONV:
            begin
                dig_next    = {corr[DIG_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next    = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + BIT_W'(1);
                if (bitcnt_reg == BIT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = B_SKIP;
                end
            end
            B_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_nib == 4'd0 && cnt_reg != CNT_W'(1))
                begin
                    dig_next = {dig_reg[DIG_W-5:0], 4'd0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.digit_char = digit_ascii(top_nib, upper_reg);
                    out_next.last_digit = (cnt_reg == CNT_W'(1));
                    dig_next            = {dig_reg[DIG_W-5:0], 4'd0};
                    cnt_next            = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        bin_reg    <= bin_next;
        bitcnt_reg <= bitcnt_next;
        cnt_reg    <= cnt_next;
        upper_reg  <= upper_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
